### src/linear_attack_key_counter_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear attack key counter unit
// Wraps concurrent assertions so that synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef LINEAR_ATTACK_KEY_COUNTER_UNIT_DEFINES_SVH
`define LINEAR_ATTACK_KEY_COUNTER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define LAKC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define LAKC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define LAKC_ASSERT(lbl, prop, msg)
`define LAKC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### src/lakc_pkg.sv
// ----------------------------------------------------------------------------
// Linear attack key counter package
// Sizes, codes, item types and small helper functions shared by the unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lakc_pkg;

  localparam int NUM_BOXES     = 4;
  localparam int BOX_BITS      = 4;
  localparam int COUNT_BITS    = 16;
  localparam int SUBKEY_W      = NUM_BOXES * BOX_BITS;
  localparam int KEY_SPACE     = 1 << SUBKEY_W;
  localparam int BOX_SIZE      = 1 << BOX_BITS;
  localparam int POS_BITS      = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
  localparam int FIELD_BITS    = 16;
  localparam int TABLE_W       = 64;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 64;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [TABLE_W-1:0]    SBOX_RESET = 64'hFEDC_BA98_7654_3210;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_SBOX    = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_BOX   = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_MASK  = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FINAL_MASKS = 8'd3;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_ACC,
    ST_ACC_TAIL,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]            op;
    logic [FIELD_BITS-1:0] plaintext;
    logic [FIELD_BITS-1:0] ciphertext;
    logic [FIELD_BITS-1:0] key_index;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] hit_count;
    logic [FIELD_BITS-1:0] deviation;
    logic [FIELD_BITS-1:0] pair_count;
  } out_item_t;

  // Box b of a block, box 0 in the most significant bits.
  function automatic logic [BOX_BITS-1:0] box_of(input logic [SUBKEY_W-1:0] word,
                                                  input int b);
    return word[(NUM_BOXES-1-b)*BOX_BITS +: BOX_BITS];
  endfunction

  // Inverse substitution; entries beyond the table read as zero.
  function automatic logic [BOX_BITS-1:0] inv_box(input logic [TABLE_W-1:0] sbox,
                                                   input logic [BOX_BITS-1:0] v);
    logic [BOX_BITS-1:0] r;
    r = '0;
    if ((int'(v) + 1) * BOX_BITS <= TABLE_W) begin
      r = sbox[int'(v)*BOX_BITS +: BOX_BITS];
    end
    return r;
  endfunction

  // Clamp a value to the width of an output field.
  function automatic logic [FIELD_BITS-1:0] sat_out(input logic [31:0] v);
    return (v > 32'hFFFF) ? '1 : v[FIELD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

### src/lakc_if.sv
// ----------------------------------------------------------------------------
// Linear attack key counter channels
// Valid/ready channels for requests, responses and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lakc_in_if import lakc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lakc_out_if import lakc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lakc_cfg_if import lakc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/lakc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lakc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/linear_attack_key_counter_unit.sv
// ----------------------------------------------------------------------------
// Linear attack key counter unit
// Last-round key recovery counter: one hit counter per candidate partial
// subkey, held in a synchronous RAM and updated by read-modify-write sweeps.
// ----------------------------------------------------------------------------
//
//  Channel     Dir  Handshake     Carries
//  in_req_i    in   valid/ready   op, plaintext, ciphertext, key_index
//  out_rsp_o   out  valid/ready   hit_count, deviation, pair_count
//  cfg_i       in   valid/ready   register index, write data (always ready)
//
// An accumulate request sweeps 2^(4*n) keys, n being the number of active
// final boxes, at one counter read-modify-write per cycle through the single
// RAM read port. After reset a clearing pass zeroes every counter in the RAM,
// and no request is taken until it ends. A stalled response waits in the
// output register while the next request is already accepted and worked on.
//
`default_nettype none

module linear_attack_key_counter_unit import lakc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  lakc_in_if.sink      in_req_i,
  lakc_out_if.source   out_rsp_o,
  lakc_cfg_if.sink     cfg_i
);

  `include "linear_attack_key_counter_unit_defines.svh"

  // Configuration registers.
  logic [TABLE_W-1:0]    inv_sbox_q;
  logic [1:0]            first_box_q;
  logic [BOX_BITS-1:0]   first_mask_q;
  logic [SUBKEY_W-1:0]   final_masks_q;

  // Control state.
  state_e                state_q, state_d;
  logic [SUBKEY_W-1:0]   sweep_q, sweep_d;
  logic [COUNT_BITS-1:0] pairs_q, pairs_d;
  logic                  s1_valid_q, s1_valid_d;
  logic                  out_valid_q, out_valid_d;

  // Per-request working registers, loaded when a request is accepted.
  logic [1:0]                              op_q;
  logic [SUBKEY_W-1:0]                     key_idx_q;
  logic                                    ppar_q;
  logic [NUM_BOXES-1:0]                    act_q;
  logic [NUM_BOXES-1:0][POS_BITS-1:0]      pos_q;
  logic [NUM_BOXES-1:0][BOX_SIZE-1:0]      par_tab_q;
  logic [SUBKEY_W-1:0]                     last_key_q;

  // Write-back stage of the sweep.
  logic [SUBKEY_W-1:0]   s1_key_q, s1_key_d;
  logic                  s1_hit_q, s1_hit_d;

  out_item_t             out_q;

  // Combinational values formed from the incoming request.
  logic                                    ppar_d;
  logic [NUM_BOXES-1:0]                    act_d;
  logic [NUM_BOXES-1:0][POS_BITS-1:0]      pos_d;
  logic [NUM_BOXES-1:0][BOX_SIZE-1:0]      par_tab_d;
  logic [SUBKEY_W-1:0]                     last_key_d;

  logic                  in_ready;
  logic                  in_fire;
  logic                  load_out;
  logic                  hit_par;
  logic                  ram_we, ram_re;
  logic [SUBKEY_W-1:0]   ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;
  logic [COUNT_BITS+1:0] diff;
  logic [COUNT_BITS+1:0] mag;
  logic [FIELD_BITS-1:0] dev;

  assign in_fire         = in_req_i.valid && in_ready;
  assign in_req_i.ready  = in_ready;
  assign cfg_i.ready     = 1'b1;
  assign out_rsp_o.valid = out_valid_q;
  assign out_rsp_o.data  = out_q;

  // Configuration writes are accepted in every cycle; indexes beyond the
  // register list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_sbox_q    <= SBOX_RESET;
      first_box_q   <= '0;
      first_mask_q  <= '0;
      final_masks_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_INV_SBOX:    inv_sbox_q    <= cfg_i.data[TABLE_W-1:0];
        REG_FIRST_BOX:   first_box_q   <= cfg_i.data[1:0];
        REG_FIRST_MASK:  first_mask_q  <= cfg_i.data[BOX_BITS-1:0];
        REG_FINAL_MASKS: final_masks_q <= cfg_i.data[SUBKEY_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-box parity tables for the incoming ciphertext. Each active final box
  // gets one parity bit per key nibble; the box position within the compacted
  // key (lowest nibble for the rightmost active box) is recorded alongside.
  always_comb begin
    logic [BOX_BITS-1:0] m;
    logic [BOX_BITS-1:0] c;
    int                  cnt;
    cnt       = 0;
    act_d     = '0;
    pos_d     = '0;
    par_tab_d = '0;
    for (int b = NUM_BOXES - 1; b >= 0; b--) begin
      m        = box_of(final_masks_q, b);
      c        = box_of(in_req_i.data.ciphertext[SUBKEY_W-1:0], b);
      act_d[b] = |m;
      pos_d[b] = POS_BITS'(cnt);
      for (int k = 0; k < BOX_SIZE; k++) begin
        par_tab_d[b][k] = ^(inv_box(inv_sbox_q, c ^ BOX_BITS'(k)) & m);
      end
      if (act_d[b]) begin
        cnt = cnt + 1;
      end
    end
    for (int i = 0; i < NUM_BOXES; i++) begin
      last_key_d[i*BOX_BITS +: BOX_BITS] = (i < cnt) ? '1 : '0;
    end
    ppar_d = 1'b0;
    if (int'(first_box_q) < NUM_BOXES) begin
      ppar_d = ^(box_of(in_req_i.data.plaintext[SUBKEY_W-1:0], int'(first_box_q))
                 & first_mask_q);
    end
  end

  // Total parity of the key being issued; zero parity is a hit.
  always_comb begin
    hit_par = ppar_q;
    for (int b = 0; b < NUM_BOXES; b++) begin
      if (act_q[b]) begin
        hit_par = hit_par ^ par_tab_q[b][sweep_q[pos_q[b]*BOX_BITS +: BOX_BITS]];
      end
    end
  end

  // Deviation |2*hits - pairs| from the counter just read.
  always_comb begin
    diff = {1'b0, ram_rdata, 1'b0} - {2'b00, pairs_q};
    mag  = diff[COUNT_BITS+1] ? (~diff + 1'b1) : diff;
    dev  = sat_out(32'(mag));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (&sweep_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_req_i.data.op)
            OP_ACCUM: state_d = ST_ACC;
            OP_READ:  state_d = ST_READ;
            OP_CLEAR: state_d = ST_CLEAR;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (&sweep_q) state_d = ST_DONE;
      end
      ST_ACC: begin
        if (sweep_q == last_key_q) state_d = ST_ACC_TAIL;
      end
      ST_ACC_TAIL: state_d = ST_DONE;
      ST_READ:     state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_rsp_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    in_ready   = 1'b0;
    load_out   = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = sweep_q;
    ram_we     = 1'b0;
    ram_waddr  = s1_key_q;
    ram_wdata  = ram_rdata + 1'b1;
    sweep_d    = sweep_q;
    pairs_d    = pairs_q;
    s1_valid_d = 1'b0;
    s1_key_d   = sweep_q;
    s1_hit_d   = ~hit_par;

    // Write-back of the counter read in the previous cycle.
    if (s1_valid_q && s1_hit_q && (ram_rdata != COUNT_MAX)) begin
      ram_we = 1'b1;
    end

    case (state_q)
      ST_INIT, ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = '0;
        sweep_d   = sweep_q + 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        sweep_d  = '0;
        if (in_fire && (in_req_i.data.op == OP_CLEAR)) begin
          pairs_d = '0;
        end
      end
      ST_ACC: begin
        ram_re     = 1'b1;
        s1_valid_d = 1'b1;
        sweep_d    = (sweep_q == last_key_q) ? '0 : sweep_q + 1'b1;
      end
      ST_ACC_TAIL: begin
        if (pairs_q != COUNT_MAX) pairs_d = pairs_q + 1'b1;
      end
      ST_READ: begin
        ram_re    = 1'b1;
        ram_raddr = key_idx_q;
      end
      ST_DONE: begin
        load_out = !out_valid_q || out_rsp_o.ready;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= '0;
      pairs_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      pairs_q     <= pairs_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q       <= in_req_i.data.op;
      key_idx_q  <= in_req_i.data.key_index[SUBKEY_W-1:0];
      ppar_q     <= ppar_d;
      act_q      <= act_d;
      pos_q      <= pos_d;
      par_tab_q  <= par_tab_d;
      last_key_q <= last_key_d;
    end
    s1_key_q <= s1_key_d;
    s1_hit_q <= s1_hit_d;
    if (load_out) begin
      out_q.hit_count  <= (op_q == OP_READ) ? sat_out(32'(ram_rdata)) : '0;
      out_q.deviation  <= (op_q == OP_READ) ? dev : '0;
      out_q.pair_count <= sat_out(32'(pairs_q));
    end
  end

  lakc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (KEY_SPACE)
  ) u_counter_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A read never meets a write to the same counter in one cycle.
  `LAKC_ASSERT_NEVER(a_rw_same_entry, ram_we && ram_re && (ram_waddr == ram_raddr), "RAM clash")
  // A waiting response is never overwritten.
  `LAKC_ASSERT_NEVER(a_out_overwrite, load_out && out_valid_q && !out_rsp_o.ready, "lost response")
  // The sweep tail always carries the last key's write-back.
  `LAKC_ASSERT(a_tail_pending, (state_q == ST_ACC_TAIL) |-> s1_valid_q, "tail write lost")
  // An accepted request always leaves the idle state.
  `LAKC_ASSERT(a_accept_busy, in_fire |=> (state_q != ST_IDLE), "request accepted without work")

endmodule

`default_nettype wire

### test/linear_attack_key_counter_unit_tb.sv
// ----------------------------------------------------------------------------
// Linear attack key counter unit testbench
// A short directed table is followed by randomized configuration phases. The
// bench keeps its own copy of every key hit counter and the pair count, and
// checks each response against it. Both channels stall at random, and the
// response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_attack_key_counter_unit_tb;
  import lakc_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 6;
  localparam int IDLE_PCT       = 23;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_ITEMS    = 16;
  localparam int QUIET_PHASE    = 2;       // phase that runs with no idling at all
  localparam int HOLD_AT        = 44;      // responses seen before the long hold-off
  // The hold-off outlasts the longest single request (a clear or a full sweep),
  // so the block always ends up with a full output register and a stalled input.
  localparam int HOLD_CYCLES    = 70_000;
  localparam int SETTLE_CYCLES  = 8;
  // A full four-box sweep or a clear runs with nothing accepted, and so does
  // the clearing pass after reset; the long hold-off outlasts each of them.
  // The watchdog allows several of those.
  localparam int WATCHDOG_LIMIT = 300_000;

  // The op field is two bits wide but only three codes are defined. The
  // fourth one must leave the counters alone.
  localparam logic [1:0]            OP_UNUSED = 2'd3;
  localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;

  // One row of the directed table: either a register write or a request,
  // the latter optionally with a response typed in by hand.
  typedef struct {
    bit                       is_write;
    logic [CFG_IDX_BITS-1:0]  reg_index;
    logic [CFG_DATA_BITS-1:0] reg_value;
    in_item_t                 req;
    bit                       typed;
    out_item_t                rsp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lakc_in_if  in_req ();
  lakc_out_if out_rsp ();
  lakc_cfg_if cfg ();

  linear_attack_key_counter_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req),
    .out_rsp_o (out_rsp),
    .cfg_i     (cfg)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bench copy of the block state and its configuration registers.
  // --------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] key_hits [KEY_SPACE];
  logic [COUNT_BITS-1:0] pairs_total;
  logic [TABLE_W-1:0]    inv_table;
  logic [1:0]            start_box;
  logic [BOX_BITS-1:0]   start_mask;
  logic [SUBKEY_W-1:0]   tail_masks;

  out_item_t awaited_reports [$];   // responses still owed by the block, oldest first
  int        idle_pct;
  int        results_seen;
  int        quiet_cycles;
  bit        failed;

  // Box b of a block, box 0 in the top bits.
  function automatic logic [BOX_BITS-1:0] box_at(input logic [SUBKEY_W-1:0] word,
                                                 input int b);
    return BOX_BITS'(word >> ((NUM_BOXES - 1 - b) * BOX_BITS));
  endfunction

  // Inverse substitution; an entry that lies past the 64-bit table reads as 0.
  function automatic logic [BOX_BITS-1:0] undo_sbox(input logic [BOX_BITS-1:0] v);
    int unsigned sh;
    sh = int'(v) * BOX_BITS;
    if (sh >= TABLE_W) return '0;
    return BOX_BITS'(inv_table >> sh);
  endfunction

  task automatic note_register(input logic [CFG_IDX_BITS-1:0]  idx,
                               input logic [CFG_DATA_BITS-1:0] value);
    case (idx)
      REG_INV_SBOX:    inv_table  = value;
      REG_FIRST_BOX:   start_box  = value[1:0];
      REG_FIRST_MASK:  start_mask = value[BOX_BITS-1:0];
      REG_FINAL_MASKS: tail_masks = value[SUBKEY_W-1:0];
      default: ;
    endcase
  endtask

  // Applies one request to the bench state and works out its response.
  task automatic count_request(input in_item_t req, output out_item_t rsp);
    logic                par_tab [NUM_BOXES][BOX_SIZE];
    logic                plain_par;
    logic                par;
    logic [BOX_BITS-1:0] m;
    logic [BOX_BITS-1:0] c;
    logic [BOX_BITS-1:0] nib;
    int                  active;
    int                  nkeys;
    int                  dev;
    rsp = '0;
    case (req.op)
      OP_ACCUM: begin
        // Parity of the masked starting plaintext box. With two index bits
        // and four boxes the index is always in range, but keep the check.
        plain_par = 1'b0;
        if (int'(start_box) < NUM_BOXES) begin
          plain_par = ^(box_at(req.plaintext, int'(start_box)) & start_mask);
        end
        // Per active final box, the masked parity for every key nibble.
        active = 0;
        for (int b = 0; b < NUM_BOXES; b++) begin
          m = box_at(tail_masks, b);
          if (m != '0) begin
            c = box_at(req.ciphertext, b);
            for (int k = 0; k < BOX_SIZE; k++) begin
              par_tab[active][k] = ^(undo_sbox(c ^ BOX_BITS'(k)) & m);
            end
            active++;
          end
        end
        // With no active box the key space is the single key 0.
        nkeys = 1 << (active * BOX_BITS);
        for (int key = 0; key < nkeys; key++) begin
          par = plain_par;
          for (int j = 0; j < active; j++) begin
            nib = BOX_BITS'(key >> ((active - 1 - j) * BOX_BITS));
            par ^= par_tab[j][nib];
          end
          if (!par && key_hits[key] != COUNT_MAX) key_hits[key]++;
        end
        if (pairs_total != COUNT_MAX) pairs_total++;
      end
      OP_READ: begin
        rsp.hit_count = key_hits[req.key_index];
        dev = 2 * int'(key_hits[req.key_index]) - int'(pairs_total);
        if (dev < 0) dev = -dev;
        rsp.deviation = (dev > int'(FIELD_MAX)) ? FIELD_MAX : FIELD_BITS'(dev);
      end
      OP_CLEAR: begin
        foreach (key_hits[i]) key_hits[i] = '0;
        pairs_total = '0;
      end
      default: ;
    endcase
    rsp.pair_count = pairs_total;
  endtask

  // --------------------------------------------------------------------------
  // Row builders for the directed table.
  // --------------------------------------------------------------------------
  function automatic stim_row_t reg_row(input logic [CFG_IDX_BITS-1:0]  idx,
                                        input logic [CFG_DATA_BITS-1:0] value);
    stim_row_t r;
    r.is_write  = 1'b1;
    r.reg_index = idx;
    r.reg_value = value;
    r.req       = '0;
    r.typed     = 1'b0;
    r.rsp       = '0;
    return r;
  endfunction

  function automatic stim_row_t req_row(input logic [1:0] op,
                                        input logic [FIELD_BITS-1:0] pt,
                                        input logic [FIELD_BITS-1:0] ct,
                                        input logic [FIELD_BITS-1:0] key);
    stim_row_t r;
    r.is_write       = 1'b0;
    r.reg_index      = '0;
    r.reg_value      = '0;
    r.req.op         = op;
    r.req.plaintext  = pt;
    r.req.ciphertext = ct;
    r.req.key_index  = key;
    r.typed          = 1'b0;
    r.rsp            = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [1:0] op,
                                          input logic [FIELD_BITS-1:0] pt,
                                          input logic [FIELD_BITS-1:0] ct,
                                          input logic [FIELD_BITS-1:0] key,
                                          input logic [FIELD_BITS-1:0] hits,
                                          input logic [FIELD_BITS-1:0] dev,
                                          input logic [FIELD_BITS-1:0] pairs);
    stim_row_t r;
    r = req_row(op, pt, ct, key);
    r.typed          = 1'b1;
    r.rsp.hit_count  = hits;
    r.rsp.deviation  = dev;
    r.rsp.pair_count = pairs;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Valid stays high from one accepted request to the next
  // unless the bench decides to idle, so it is never dropped and raised in
  // the same time step. A request is taken at the edge where valid and ready
  // are both high; the ready seen right after the edge is the one that
  // counted there.
  // --------------------------------------------------------------------------
  task automatic send_request(input in_item_t req, input bit typed,
                              input out_item_t typed_rsp);
    out_item_t rsp;
    while ($urandom_range(99) < idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_req.valid <= 1'b1;
    in_req.data  <= req;
    @(posedge clk_i);
    while (!in_req.ready) @(posedge clk_i);
    // The bench state always advances, even when the response is typed in.
    count_request(req, rsp);
    awaited_reports.push_back(typed ? typed_rsp : rsp);
  endtask

  // Stops offering requests and waits until every owed response is in, so
  // that registers can be written with the block idle.
  task automatic drain_reports();
    in_req.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves valid high; the caller lowers it after the last write of a group.
  task automatic write_register(input logic [CFG_IDX_BITS-1:0]  idx,
                                input logic [CFG_DATA_BITS-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    note_register(idx, value);
  endtask

  // --------------------------------------------------------------------------
  // Response side: random back-pressure, plus one long hold-off while the
  // request side keeps offering, so that the block fills up and stalls its
  // input. The hold-off is counted here, independent of the request flow.
  // --------------------------------------------------------------------------
  initial begin
    bit held;
    held = 1'b0;
    out_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && !held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        out_rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_rsp.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic compare_field(input string name, input logic [FIELD_BITS-1:0] want,
                               input logic [FIELD_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  // Every accepted response is matched against the oldest owed one.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni === 1'b1 && out_rsp.valid === 1'b1 && out_rsp.ready === 1'b1) begin
      results_seen++;
      if (awaited_reports.size() == 0) begin
        $error("response with no request waiting for it");
        failed = 1'b1;
      end else begin
        want = awaited_reports.pop_front();
        compare_field("hit_count", want.hit_count, out_rsp.data.hit_count);
        compare_field("deviation", want.deviation, out_rsp.data.deviation);
        compare_field("pair_count", want.pair_count, out_rsp.data.pair_count);
      end
    end
  end

  // The watchdog counts cycles in which no channel moves anything.
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (in_req.valid && in_req.ready) ||
        (out_rsp.valid && out_rsp.ready) || (cfg.valid && cfg.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("nothing accepted for %0d cycles, %0d responses still owed",
             WATCHDOG_LIMIT, awaited_reports.size());
      $display("linear_attack_key_counter_unit_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t           directed_rows [$];
    in_item_t            req;
    logic [SUBKEY_W-1:0] tail;
    logic [SUBKEY_W-1:0] span;
    int                  n_active;
    int                  placed;
    int                  pick;
    int                  b;
    bit                  cfg_open;

    in_req.valid <= 1'b0;
    in_req.data  <= '0;
    cfg.valid    <= 1'b0;
    cfg.index    <= '0;
    cfg.data     <= '0;
    rst_ni       <= 1'b0;

    foreach (key_hits[i]) key_hits[i] = '0;
    pairs_total  = '0;
    inv_table    = SBOX_RESET;
    start_box    = '0;
    start_mask   = '0;
    tail_masks   = '0;
    idle_pct     = IDLE_PCT;
    results_seen = 0;
    quiet_cycles = 0;
    failed       = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first rows run with the reset configuration: identity table, no
    // plaintext mask and no active final box. The key space is then the single
    // key 0 and every pair hits it. The next groups take the table to all
    // zeros with all four final boxes active (a full 2^16 sweep), then to all
    // ones with the two outer boxes active, then to a scrambled table.
    directed_rows = '{
      typed_row(OP_READ,   16'h0000, 16'h0000, 16'h0000, 16'd0, 16'd0, 16'd0),
      typed_row(OP_READ,   16'h0000, 16'h0000, 16'hFFFF, 16'd0, 16'd0, 16'd0),
      typed_row(OP_ACCUM,  16'h0000, 16'h0000, 16'h0000, 16'd0, 16'd0, 16'd1),
      typed_row(OP_ACCUM,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd2),
      typed_row(OP_READ,   16'h0000, 16'h0000, 16'h0000, 16'd2, 16'd2, 16'd2),
      typed_row(OP_READ,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd2, 16'd2),
      typed_row(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd2),
      reg_row(REG_INV_SBOX,    64'h0000_0000_0000_0000),
      reg_row(REG_FIRST_BOX,   64'd3),
      reg_row(REG_FIRST_MASK,  64'hF),
      reg_row(REG_FINAL_MASKS, 64'hFFFF),
      // The table maps everything to zero, so only the plaintext parity counts.
      typed_row(OP_ACCUM,  16'h0001, 16'h1234, 16'h0000, 16'd0, 16'd0, 16'd3),
      typed_row(OP_ACCUM,  16'h0003, 16'hFFFF, 16'h0000, 16'd0, 16'd0, 16'd4),
      typed_row(OP_READ,   16'h0000, 16'h0000, 16'hFFFF, 16'd1, 16'd2, 16'd4),
      typed_row(OP_READ,   16'h0000, 16'h0000, 16'h0000, 16'd3, 16'd2, 16'd4),
      reg_row(REG_INV_SBOX,    64'hFFFF_FFFF_FFFF_FFFF),
      reg_row(REG_FIRST_BOX,   64'd0),
      reg_row(REG_FIRST_MASK,  64'h8),
      reg_row(REG_FINAL_MASKS, 64'hF00F),
      typed_row(OP_ACCUM,  16'h8000, 16'h0000, 16'h0000, 16'd0, 16'd0, 16'd5),
      typed_row(OP_ACCUM,  16'h7FFF, 16'hABCD, 16'h0000, 16'd0, 16'd0, 16'd6),
      req_row(OP_READ,     16'h0000, 16'h0000, 16'h00FF),
      reg_row(REG_INV_SBOX,    64'h5EF8_C12D_B463_079A),
      reg_row(REG_FIRST_BOX,   64'd2),
      reg_row(REG_FIRST_MASK,  64'h5),
      reg_row(REG_FINAL_MASKS, 64'h0A30),
      req_row(OP_ACCUM,    16'h1234, 16'h5678, 16'h0000),
      req_row(OP_ACCUM,    16'hFEDC, 16'h0F0F, 16'h0000),
      req_row(OP_READ,     16'h0000, 16'h0000, 16'h0012),
      req_row(OP_READ,     16'h0000, 16'h0000, 16'h1200),
      typed_row(OP_CLEAR,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0),
      typed_row(OP_READ,   16'h0000, 16'h0000, 16'h0000, 16'd0, 16'd0, 16'd0),
      req_row(OP_ACCUM,    16'hA5A5, 16'h5A5A, 16'h0000),
      req_row(OP_READ,     16'h0000, 16'h0000, 16'h00A5)
    };

    // Register groups are written only once the block has answered every
    // request before them.
    cfg_open = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        if (!cfg_open) drain_reports();
        write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg.valid <= 1'b0;
        cfg_open = 1'b0;
        send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      end
    end

    // Random phases. Each starts from an idle block with a fresh configuration.
    // Most phases keep the key space small (one or two active boxes) so that
    // the sweeps stay short; the full sweep was covered above. Random upper
    // bits on the narrow registers must be ignored by the block.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_reports();
      pick     = $urandom_range(99);
      n_active = (pick < 15) ? 0 : (pick < 60) ? 1 : (pick < 90) ? 2 : 3;
      tail     = '0;
      placed   = 0;
      while (placed < n_active) begin
        b = $urandom_range(NUM_BOXES - 1);
        if (box_at(tail, b) == '0) begin
          tail[(NUM_BOXES - 1 - b) * BOX_BITS +: BOX_BITS] =
            BOX_BITS'($urandom_range(BOX_SIZE - 1, 1));
          placed++;
        end
      end
      write_register(REG_INV_SBOX, {$urandom, $urandom});
      write_register(REG_FIRST_BOX, {$urandom, $urandom});
      write_register(REG_FIRST_MASK, {$urandom, $urandom});
      write_register(REG_FINAL_MASKS, {$urandom, 16'($urandom), tail});
      cfg.valid <= 1'b0;
      span     = SUBKEY_W'((1 << (n_active * BOX_BITS)) - 1);
      idle_pct = (ph == QUIET_PHASE) ? 0 : IDLE_PCT;

      // Mostly pairs and reads of keys inside the active key space, so the
      // counters read back carry real hit counts; a few reads go anywhere,
      // and clears and the unused op come in rarely.
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick           = $urandom_range(99);
        req.plaintext  = FIELD_BITS'($urandom);
        req.ciphertext = FIELD_BITS'($urandom);
        req.key_index  = FIELD_BITS'($urandom);
        if (pick < 55) begin
          req.op = OP_ACCUM;
        end else if (pick < 90) begin
          req.op = OP_READ;
          if ($urandom_range(4) != 0) req.key_index &= span;
        end else if (pick < 97) begin
          req.op = OP_UNUSED;
        end else begin
          req.op = OP_CLEAR;
        end
        send_request(req, 1'b0, '0);
      end
    end

    drain_reports();
    if (!failed) begin
      $display("linear_attack_key_counter_unit_tb passed");
    end else begin
      $display("linear_attack_key_counter_unit_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+src
src/lakc_pkg.sv
src/lakc_if.sv
src/lakc_ram.sv
src/linear_attack_key_counter_unit.sv
test/linear_attack_key_counter_unit_tb.sv
